// ===== design/rlt_pkg.sv =====
// Shared types and constants for the reservation and limit tag unit.
`default_nettype none

package rlt_pkg;

  localparam int TAG_W = 63;
  localparam int BW_W = 32;
  localparam int BLK_W = 16;
  localparam int NUM_W = 36;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = BW_W;

  localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};
  localparam logic [NUM_W-1:0] US_PER_S = NUM_W'(1000000);

  localparam logic [BW_W-1:0] LIMIT_BW_RESET = BW_W'(1048576);
  localparam logic [BW_W-1:0] RESERVE_BW_RESET = BW_W'(1024);
  localparam logic [BLK_W-1:0] BLOCK_KB_RESET = BLK_W'(128);

  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LIMIT_BW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_RESERVE_BW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LIMIT_BW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_RESERVE_BW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_KB = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_PICK,
    ST_ADD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic step;
    logic pick;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic bw_zero;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/rlt_ctrl.sv =====
// Sequencer for the tag unit: steps one transaction through the datapath.
`default_nettype none

module rlt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire rlt_pkg::stat_t stat,
  output rlt_pkg::cmd_t      cmd
);
  import rlt_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: state_next = ST_DIV;
      ST_DIV: begin
        if (stat.bw_zero || stat.div_done) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: state_next = ST_ADD;
      ST_ADD: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_DIV: cmd.step = !stat.bw_zero;
      ST_PICK: cmd.pick = 1'b1;
      ST_ADD: cmd.commit = 1'b1;
      ST_FIN: cmd.out_load = out_free;
      default: in_stall = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/rlt_dp.sv =====
// Datapath for the tag unit: registers, tag state, divider and saturating adder.
`default_nettype none

module rlt_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rlt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rlt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              mode,
  input  wire logic                              is_write,
  input  wire logic [rlt_pkg::TAG_W-1:0]         time_us,
  input  wire logic [rlt_pkg::TAG_W-1:0]         request_limit_tag,
  output logic [rlt_pkg::TAG_W-1:0]              tag_us,
  output logic                                   flag,
  input  wire rlt_pkg::cmd_t                     cmd,
  output rlt_pkg::stat_t                         stat
);
  import rlt_pkg::*;

  logic [BW_W-1:0]  write_limit_bw;
  logic [BW_W-1:0]  write_reserve_bw;
  logic [BW_W-1:0]  read_limit_bw;
  logic [BW_W-1:0]  read_reserve_bw;
  logic [BLK_W-1:0] block_kb;

  logic [TAG_W-1:0] write_limit_last;
  logic [TAG_W-1:0] write_reserve_last;
  logic [TAG_W-1:0] read_limit_last;
  logic [TAG_W-1:0] read_reserve_last;

  logic             req_mode;
  logic             req_write;
  logic [TAG_W-1:0] req_time;
  logic [TAG_W-1:0] req_limit;

  logic [BW_W-1:0]  divisor;
  logic [BW_W-1:0]  rem;
  logic [NUM_W-1:0] num;
  logic [CNT_W-1:0] cnt;

  logic [TAG_W-1:0] base;
  logic [TAG_W-1:0] gap;
  logic [TAG_W-1:0] res_tag;
  logic             res_flag;

  logic [BW_W:0]    trial;
  logic [BW_W:0]    diff;
  logic             ge;
  logic [TAG_W-1:0] limit_cur;
  logic [TAG_W-1:0] reserve_cur;
  logic             restart;
  logic [TAG_W:0]   sum;
  logic [TAG_W-1:0] new_tag;

  assign trial = {rem, num[NUM_W-1]};
  assign diff = trial - {1'b0, divisor};
  assign ge = trial >= {1'b0, divisor};

  assign limit_cur = req_write ? write_limit_last : read_limit_last;
  assign reserve_cur = req_write ? write_reserve_last : read_reserve_last;
  assign restart = req_time > reserve_cur;

  assign sum = {1'b0, base} + {1'b0, gap};
  assign new_tag = (sum >= {1'b0, TAG_MAX}) ? TAG_MAX : sum[TAG_W-1:0];

  assign stat.bw_zero = divisor == '0;
  assign stat.div_done = cnt == CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_limit_bw <= LIMIT_BW_RESET;
      write_reserve_bw <= RESERVE_BW_RESET;
      read_limit_bw <= LIMIT_BW_RESET;
      read_reserve_bw <= RESERVE_BW_RESET;
      block_kb <= BLOCK_KB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WRITE_LIMIT_BW: write_limit_bw <= cfg_data;
        CFG_WRITE_RESERVE_BW: write_reserve_bw <= cfg_data;
        CFG_READ_LIMIT_BW: read_limit_bw <= cfg_data;
        CFG_READ_RESERVE_BW: read_reserve_bw <= cfg_data;
        CFG_BLOCK_KB: block_kb <= cfg_data[BLK_W-1:0];
        default: block_kb <= block_kb;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode <= mode;
      req_write <= is_write;
      req_time <= time_us;
      req_limit <= request_limit_tag;
    end
    if (cmd.prep) begin
      num <= US_PER_S * NUM_W'(block_kb);
      rem <= '0;
      cnt <= '0;
      if (req_mode) begin
        divisor <= req_write ? write_reserve_bw : read_reserve_bw;
      end else begin
        divisor <= req_write ? write_limit_bw : read_limit_bw;
      end
    end
    if (cmd.step) begin
      rem <= ge ? diff[BW_W-1:0] : trial[BW_W-1:0];
      num <= {num[NUM_W-2:0], ge};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.pick) begin
      gap <= stat.bw_zero ? TAG_MAX : TAG_W'(num);
      base <= req_mode ? (restart ? req_time : reserve_cur) : limit_cur;
      res_flag <= !restart;
    end
    if (cmd.commit) begin
      res_tag <= new_tag;
    end
    if (cmd.out_load) begin
      tag_us <= res_tag;
      flag <= req_mode ? res_flag : (req_time >= res_tag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_limit_last <= '0;
      write_reserve_last <= '0;
      read_limit_last <= '0;
      read_reserve_last <= '0;
    end else begin
      if (cmd.pick && req_mode && restart) begin
        if (req_write) begin
          write_limit_last <= req_limit;
        end else begin
          read_limit_last <= req_limit;
        end
      end
      if (cmd.commit) begin
        unique case ({req_mode, req_write})
          2'b00: read_limit_last <= new_tag;
          2'b01: write_limit_last <= new_tag;
          2'b10: read_reserve_last <= new_tag;
          2'b11: write_reserve_last <= new_tag;
          default: read_limit_last <= read_limit_last;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/reservation_limit_tag_unit.sv =====
// Top level of the reservation and limit tag unit.
// Each transaction computes one limit or reservation tag for the read or write
// side and returns one result. After acceptance, an item forms the numerator
// 1000000 * block_kb, runs it through the restoring divider that yields one
// quotient bit per cycle for a 36-bit quotient, picks the base tag, adds the
// spacing with saturation and loads the result into the output register. A
// bandwidth of zero bypasses the divider. The unit holds one item at a time and
// stalls its input until that item's result is in the output register, and it
// can accept the next item in the same cycle that the result appears there.
// A result waiting there does not block acceptance of the next item, but while it
// is stalled the next result cannot be loaded and the unit keeps its input stalled.
`default_nettype none

module reservation_limit_tag_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rlt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode,
  input  wire logic                           is_write,
  input  wire logic [rlt_pkg::TAG_W-1:0]      time_us,
  input  wire logic [rlt_pkg::TAG_W-1:0]      request_limit_tag,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rlt_pkg::TAG_W-1:0]           tag_us,
  output logic                                flag
);
  import rlt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlt_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mode              (mode),
    .is_write          (is_write),
    .time_us           (time_us),
    .request_limit_tag (request_limit_tag),
    .tag_us            (tag_us),
    .flag              (flag),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

`default_nettype wire

// ===== design/rlt_checker.sv =====
// Port-level assertions for the tag unit and the bind that attaches them.
`default_nettype none

module rlt_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [rlt_pkg::TAG_W-1:0]      tag_us,
  input wire logic                           flag
);

  // An accepted transaction keeps the unit busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepted transaction");

  // When the unit is idle, a taken result is not replaced by a new one.
  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !in_stall) |=> !out_valid)
    else $error("result appeared without an accepted transaction");

  // Finishing an item always leaves its result in the output register.
  a_result_on_finish: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid)
    else $error("item finished without a result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(tag_us) && $stable(flag)))
    else $error("stalled result changed");

endmodule

bind reservation_limit_tag_unit rlt_checker u_rlt_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the reservation and limit tag unit.
module testbench;
  import rlt_pkg::*;

  localparam logic MODE_LIMIT = 1'b0;
  localparam logic MODE_RESERVE = 1'b1;
  localparam logic SIDE_READ = 1'b0;
  localparam logic SIDE_WRITE = 1'b1;
  localparam logic [63:0] TAG_CEIL = {1'b0, TAG_MAX};
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic flag;
  } tag_result_t;

  class tag_predictor;
    logic [BW_W-1:0] limit_bw [2];
    logic [BW_W-1:0] reserve_bw [2];
    logic [BLK_W-1:0] block_kb;
    logic [63:0] limit_last [2];
    logic [63:0] reserve_last [2];
    tag_result_t expected_tags [$];
    int errors;

    function new();
      limit_bw[0] = LIMIT_BW_RESET;
      limit_bw[1] = LIMIT_BW_RESET;
      reserve_bw[0] = RESERVE_BW_RESET;
      reserve_bw[1] = RESERVE_BW_RESET;
      block_kb = BLOCK_KB_RESET;
      limit_last[0] = '0;
      limit_last[1] = '0;
      reserve_last[0] = '0;
      reserve_last[1] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WRITE_LIMIT_BW: limit_bw[SIDE_WRITE] = data;
        CFG_WRITE_RESERVE_BW: reserve_bw[SIDE_WRITE] = data;
        CFG_READ_LIMIT_BW: limit_bw[SIDE_READ] = data;
        CFG_READ_RESERVE_BW: reserve_bw[SIDE_READ] = data;
        CFG_BLOCK_KB: block_kb = data[BLK_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] spacing(logic [BW_W-1:0] bw);
      if (bw == '0) return TAG_CEIL;
      return (64'(US_PER_S) * 64'(block_kb)) / 64'(bw);
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] base;
      base = a & TAG_CEIL;
      if (b >= TAG_CEIL - base) return TAG_CEIL;
      return base + b;
    endfunction

    function logic [63:0] next_limit_tag(logic w);
      return sat_add(limit_last[w], spacing(limit_bw[w]));
    endfunction

    function void note_request(logic m, logic w, logic [TAG_W-1:0] t, logic [TAG_W-1:0] r);
      tag_result_t exp;
      if (m == MODE_LIMIT) begin
        limit_last[w] = next_limit_tag(w);
        exp.tag = limit_last[w][TAG_W-1:0];
        exp.flag = ({1'b0, t} >= limit_last[w]);
      end else begin
        if ({1'b0, t} > reserve_last[w]) begin
          reserve_last[w] = {1'b0, t};
          limit_last[w] = {1'b0, r};
          exp.flag = 1'b0;
        end else begin
          exp.flag = 1'b1;
        end
        reserve_last[w] = sat_add(reserve_last[w], spacing(reserve_bw[w]));
        exp.tag = reserve_last[w][TAG_W-1:0];
      end
      expected_tags.push_back(exp);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_tag(logic [TAG_W-1:0] tag, logic flag);
      tag_result_t exp;
      if (expected_tags.size() == 0) begin
        report_mismatch($sformatf("unexpected result tag_us=%0d flag=%0b", tag, flag));
        return;
      end
      exp = expected_tags.pop_front();
      if (tag !== exp.tag)
        report_mismatch($sformatf("tag_us got %0d want %0d", tag, exp.tag));
      if (flag !== exp.flag)
        report_mismatch($sformatf("flag got %0b want %0b (tag_us %0d)", flag, exp.flag, exp.tag));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = 1'b0;
  logic is_write = 1'b0;
  logic [TAG_W-1:0] time_us = '0;
  logic [TAG_W-1:0] request_limit_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TAG_W-1:0] tag_us;
  logic flag;

  tag_predictor predictor;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  reservation_limit_tag_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .is_write(is_write),
    .time_us(time_us),
    .request_limit_tag(request_limit_tag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tag_us(tag_us),
    .flag(flag)
  );

  always @(posedge clk) begin
    if (out_valid && !out_stall) predictor.check_tag(tag_us, flag);
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic m, input logic w, input logic [TAG_W-1:0] t,
                              input logic [TAG_W-1:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    is_write <= w;
    time_us <= t;
    request_limit_tag <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predictor.note_request(m, w, t, r);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    predictor.write_reg(idx, data);
  endtask

  task automatic wait_for_tags();
    in_valid <= 1'b0;
    while (predictor.expected_tags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [BW_W-1:0] pick_bandwidth();
    int k;
    k = $urandom_range(9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k < 4) return $urandom;
    if (k < 7) return BW_W'($urandom_range(1, 1000));
    return BW_W'($urandom_range(1000, 1 << 22));
  endfunction

  task automatic configure_phase(input int phase);
    logic [BW_W-1:0] bw [4];
    logic [CFG_DATA_W-1:0] blk;
    case (phase)
      0: begin
        foreach (bw[i]) bw[i] = '1;
        blk = CFG_DATA_W'(1);
      end
      1: begin
        foreach (bw[i]) bw[i] = BW_W'(1);
        blk = {16'($urandom), 16'hFFFF};
      end
      2: begin
        foreach (bw[i]) bw[i] = '0;
        blk = CFG_DATA_W'(BLOCK_KB_RESET);
      end
      3: begin
        foreach (bw[i]) bw[i] = pick_bandwidth();
        blk = {16'($urandom), 16'h0000};
      end
      default: begin
        foreach (bw[i]) bw[i] = pick_bandwidth();
        blk = {16'($urandom),
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 256))};
      end
    endcase
    program_register(CFG_WRITE_LIMIT_BW, bw[0]);
    program_register(CFG_WRITE_RESERVE_BW, bw[1]);
    program_register(CFG_READ_LIMIT_BW, bw[2]);
    program_register(CFG_READ_RESERVE_BW, bw[3]);
    program_register(CFG_BLOCK_KB, blk);
    if (phase == 4) begin
      for (int i = CFG_BLOCK_KB + 1; i < (1 << CFG_IDX_W); i++)
        program_register(CFG_IDX_W'(i), $urandom);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Times mostly land close to the tag the request is compared against.
  function automatic logic [TAG_W-1:0] pick_time(logic [63:0] base);
    logic [63:0] v;
    logic [63:0] off;
    int k;
    k = $urandom_range(99);
    off = ($urandom_range(1) != 0) ? 64'($urandom_range(3)) : 64'($urandom_range(5000));
    if (k < 5) v = '0;
    else if (k < 10) v = TAG_CEIL;
    else if (k < 25) v = {$urandom, $urandom};
    else if (k < 62) v = (base >= TAG_CEIL - off) ? TAG_CEIL : base + off;
    else v = (base > off) ? base - off : '0;
    return v[TAG_W-1:0];
  endfunction

  task automatic offer_random_request();
    logic m;
    logic w;
    logic [63:0] base;
    logic [TAG_W-1:0] t;
    logic [TAG_W-1:0] r;
    m = 1'($urandom_range(1));
    w = 1'($urandom_range(1));
    base = (m == MODE_LIMIT) ? predictor.next_limit_tag(w) : predictor.reserve_last[w];
    t = pick_time(base);
    r = ($urandom_range(3) == 0) ? pick_time(predictor.limit_last[w]) : pick_time({1'b0, t});
    send_request(m, w, t, r);
  endtask

  task automatic run_directed();
    send_request(MODE_LIMIT, SIDE_READ, '0, '0);
    send_request(MODE_LIMIT, SIDE_READ, TAG_W'(predictor.next_limit_tag(SIDE_READ)), TAG_MAX);
    send_request(MODE_LIMIT, SIDE_READ, TAG_W'(predictor.next_limit_tag(SIDE_READ) - 64'd1),
                 '0);
    send_request(MODE_LIMIT, SIDE_WRITE, TAG_MAX, TAG_MAX);
    send_request(MODE_RESERVE, SIDE_READ, '0, TAG_MAX);
    send_request(MODE_RESERVE, SIDE_READ, 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_request(MODE_RESERVE, SIDE_READ, TAG_W'(predictor.reserve_last[SIDE_READ]), '0);
    send_request(MODE_RESERVE, SIDE_READ, TAG_W'(predictor.reserve_last[SIDE_READ] + 64'd1),
                 63'd123);
    send_request(MODE_LIMIT, SIDE_READ, TAG_W'(predictor.next_limit_tag(SIDE_READ)), '0);
    send_request(MODE_RESERVE, SIDE_WRITE, TAG_MAX, TAG_MAX);
    send_request(MODE_RESERVE, SIDE_WRITE, TAG_MAX, '0);
    send_request(MODE_LIMIT, SIDE_WRITE, '0, '0);
    send_request(MODE_LIMIT, SIDE_WRITE, TAG_MAX, '0);
    send_request(MODE_RESERVE, SIDE_READ, TAG_MAX - 1, '0);
    send_request(MODE_LIMIT, SIDE_READ, TAG_MAX, TAG_MAX);
  endtask

  initial begin
    predictor = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 37;
    recv_idle_pct = 55;
    run_directed();
    wait_for_tags();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 55;
      end else if (phase < 6) begin
        send_idle_pct = 55;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      configure_phase(phase);
      if (phase == 6) hold_requests = hold_requests + 1;
      repeat (ITEMS_PER_PHASE) offer_random_request();
      wait_for_tags();
    end
    repeat (50) @(posedge clk);
    if (predictor.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rlt_pkg.sv
design/rlt_ctrl.sv
design/rlt_dp.sv
design/reservation_limit_tag_unit.sv
design/rlt_checker.sv
verif/testbench.sv
